>>> hdl/assert_macros.svh
// Assertion helpers shared by the framer modules.
// Each macro expects i_clk and i_rst_n to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define RSF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define RSF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define RSF_ASSERT(lbl, prop, msg)
`define RSF_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

>>> hdl/rsf_pkg.sv
// ----------------------------------------------------------------------------
// rsf_pkg
// Shared constants, codes and types of the silence-delimited frame block.
// ----------------------------------------------------------------------------
`default_nettype none

package rsf_pkg;

    localparam int BUFFER_DEPTH_DEF = 256;

    // input item kinds
    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_RX_BYTE = 3'd1;
    localparam logic [2:0] KIND_TX_LOAD = 3'd2;
    localparam logic [2:0] KIND_TX_RDY  = 3'd3;
    localparam logic [2:0] KIND_READ    = 3'd4;

    // result kinds
    localparam logic [1:0] OUT_TX_BYTE  = 2'd0;
    localparam logic [1:0] OUT_FRAME    = 2'd1;
    localparam logic [1:0] OUT_RD_DATA  = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W     = 2;
    localparam logic [1:0] CFG_GAP_SHORT = 2'd0;
    localparam logic [1:0] CFG_GAP_END   = 2'd1;

    localparam logic [7:0] GAP_SHORT_RST = 8'd15;
    localparam logic [7:0] GAP_END_RST   = 8'd35;

    localparam logic [8:0] LEN_MAX = 9'd511;

    // result descriptor handed from the control logic to the output pipeline
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic       hit;      // read lies inside the readable frame
        logic [8:0] len;
    } t_res;

    function automatic logic [8:0] sat_len(input logic [31:0] n);
        logic [8:0] r;
        r = (n > 32'(LEN_MAX)) ? LEN_MAX : n[8:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/rsf_rx_bank.sv
// ----------------------------------------------------------------------------
// rsf_rx_bank
// Two receive banks in one memory; the bank bit is the top address bit.
// ----------------------------------------------------------------------------
`default_nettype none

module rsf_rx_bank #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire                              i_clk,
    input  wire                              i_we,
    input  wire  [$clog2(BUFFER_DEPTH):0]    i_waddr,
    input  wire  [7:0]                       i_wdata,
    input  wire                              i_re,
    input  wire  [$clog2(BUFFER_DEPTH):0]    i_raddr,
    output logic [7:0]                       o_rdata
);
    import rsf_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic [7:0] mem [2**(AW+1)];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/rsf_tx_store.sv
// ----------------------------------------------------------------------------
// rsf_tx_store
// Transmit message memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rsf_tx_store #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire                                i_clk,
    input  wire                                i_we,
    input  wire  [$clog2(BUFFER_DEPTH)-1:0]    i_waddr,
    input  wire  [7:0]                         i_wdata,
    input  wire                                i_re,
    input  wire  [$clog2(BUFFER_DEPTH)-1:0]    i_raddr,
    output logic [7:0]                         o_rdata
);
    import rsf_pkg::*;

    logic [7:0] mem [BUFFER_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/rsf_ctrl.sv
// ----------------------------------------------------------------------------
// rsf_ctrl
// Silence timer, frame flags, buffer counts and gap registers. Issues the
// memory accesses and a result descriptor for frame ends, sent bytes and reads.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rsf_ctrl #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // configuration writes
    input  wire                                   i_cfg_we,
    input  wire  [rsf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire  [7:0]                            i_cfg_data,
    // accepted item
    input  wire                                   i_acc,
    input  wire  [2:0]                            i_kind,
    input  wire  [7:0]                            i_data_byte,
    input  wire                                   i_is_last,
    input  wire  [7:0]                            i_read_index,
    input  wire                                   i_release_req,
    // receive memory
    output logic                                  o_rx_we,
    output logic [$clog2(BUFFER_DEPTH):0]         o_rx_waddr,
    output logic                                  o_rx_re,
    output logic [$clog2(BUFFER_DEPTH):0]         o_rx_raddr,
    // transmit memory
    output logic                                  o_tx_we,
    output logic [$clog2(BUFFER_DEPTH)-1:0]       o_tx_waddr,
    output logic                                  o_tx_re,
    output logic [$clog2(BUFFER_DEPTH)-1:0]       o_tx_raddr,
    output logic [7:0]                            o_wdata,
    // result descriptor
    output rsf_pkg::t_res                         o_res
);
    import rsf_pkg::*;

    localparam int          AW    = $clog2(BUFFER_DEPTH);
    localparam int          CW    = AW + 1;
    localparam logic [CW-1:0] DEPTH = CW'(BUFFER_DEPTH);

    logic [7:0]    r_gap_short, n_gap_short;
    logic [7:0]    r_gap_end,   n_gap_end;
    logic [7:0]    r_sc,        n_sc;
    logic          r_running,   n_running;
    logic          r_nf,        n_nf;
    logic          r_done,      n_done;
    logic          r_bs,        n_bs;
    logic [CW-1:0] r_rc,        n_rc;
    logic [CW-1:0] r_readable,  n_readable;
    logic [CW-1:0] r_lc,        n_lc;
    logic [CW-1:0] r_pos,       n_pos;
    logic [CW-1:0] r_slen,      n_slen;
    logic          r_sen,       n_sen;

    logic [7:0]    sc_inc;
    logic [CW-1:0] rc_eff;
    logic [CW-1:0] lc_inc;
    logic [CW-1:0] pos_inc;
    logic          rd_hit;

    assign sc_inc  = (r_sc != 8'hFF) ? r_sc + 8'd1 : r_sc;
    assign rc_eff  = r_nf ? '0 : r_rc;
    assign lc_inc  = (r_lc < DEPTH) ? r_lc + CW'(1) : r_lc;
    assign pos_inc = r_pos + CW'(1);
    assign rd_hit  = (32'(i_read_index) < 32'(r_readable))
                  && (32'(i_read_index) < 32'(BUFFER_DEPTH));
    assign o_wdata = i_data_byte;

    always_comb begin
        n_gap_short = r_gap_short;
        n_gap_end   = r_gap_end;
        n_sc        = r_sc;
        n_running   = r_running;
        n_nf        = r_nf;
        n_done      = r_done;
        n_bs        = r_bs;
        n_rc        = r_rc;
        n_readable  = r_readable;
        n_lc        = r_lc;
        n_pos       = r_pos;
        n_slen      = r_slen;
        n_sen       = r_sen;
        o_rx_we     = 1'b0;
        o_rx_waddr  = {r_bs, rc_eff[AW-1:0]};
        o_rx_re     = 1'b0;
        o_rx_raddr  = {~r_bs, AW'(i_read_index)};
        o_tx_we     = 1'b0;
        o_tx_waddr  = r_lc[AW-1:0];
        o_tx_re     = 1'b0;
        o_tx_raddr  = r_pos[AW-1:0];
        o_res       = '0;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAP_SHORT: n_gap_short = i_cfg_data;
                CFG_GAP_END:   n_gap_end   = i_cfg_data;
                default: ;
            endcase
        end

        if (i_acc) begin
            unique case (i_kind)
                KIND_TICK: begin
                    if (r_running) begin
                        n_sc = sc_inc;
                        if (sc_inc >= r_gap_short && sc_inc < r_gap_end) begin
                            n_nf = 1'b1;
                        end
                        if (sc_inc >= r_gap_end) begin
                            n_running = 1'b0;
                            n_done    = 1'b1;
                            if (r_slen != '0) begin
                                n_sen = 1'b1;
                            end
                            // swap banks: finished frame becomes readable
                            if (r_rc != '0) begin
                                n_bs        = ~r_bs;
                                n_readable  = r_rc;
                                n_rc        = '0;
                                o_res.valid = 1'b1;
                                o_res.kind  = OUT_FRAME;
                                o_res.len   = sat_len(32'(r_rc));
                            end
                        end
                    end
                end
                KIND_RX_BYTE: begin
                    n_sc      = '0;
                    n_running = 1'b1;
                    n_nf      = 1'b0;
                    n_done    = 1'b0;
                    if (rc_eff < DEPTH) begin
                        o_rx_we = 1'b1;
                        n_rc    = rc_eff + CW'(1);
                    end else begin
                        n_rc    = rc_eff;
                    end
                end
                KIND_TX_LOAD: begin
                    o_tx_we = (r_lc < DEPTH);
                    if (i_is_last) begin
                        n_slen = lc_inc;
                        n_pos  = '0;
                        n_lc   = '0;
                        if (r_done && lc_inc != '0) begin
                            n_sen = 1'b1;
                        end
                    end else begin
                        n_lc = lc_inc;
                    end
                end
                KIND_TX_RDY: begin
                    if (r_sen && r_pos < r_slen && r_pos < DEPTH) begin
                        n_sc        = '0;
                        n_running   = 1'b1;
                        n_nf        = 1'b0;
                        n_done      = 1'b0;
                        o_tx_re     = 1'b1;
                        o_res.valid = 1'b1;
                        o_res.kind  = OUT_TX_BYTE;
                        if (pos_inc >= r_slen) begin
                            n_slen = '0;
                            n_pos  = '0;
                            n_sen  = 1'b0;
                        end else begin
                            n_pos  = pos_inc;
                        end
                    end
                end
                KIND_READ: begin
                    o_rx_re     = 1'b1;
                    o_res.valid = 1'b1;
                    o_res.kind  = OUT_RD_DATA;
                    o_res.hit   = rd_hit;
                    o_res.len   = sat_len(32'(r_readable));
                    if (i_release_req) begin
                        n_readable = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_short <= GAP_SHORT_RST;
            r_gap_end   <= GAP_END_RST;
            r_sc        <= '0;
            r_running   <= 1'b0;
            r_nf        <= 1'b1;
            r_done      <= 1'b1;
            r_bs        <= 1'b0;
            r_rc        <= '0;
            r_readable  <= '0;
            r_lc        <= '0;
            r_pos       <= '0;
            r_slen      <= '0;
            r_sen       <= 1'b0;
        end else begin
            r_gap_short <= n_gap_short;
            r_gap_end   <= n_gap_end;
            r_sc        <= n_sc;
            r_running   <= n_running;
            r_nf        <= n_nf;
            r_done      <= n_done;
            r_bs        <= n_bs;
            r_rc        <= n_rc;
            r_readable  <= n_readable;
            r_lc        <= n_lc;
            r_pos       <= n_pos;
            r_slen      <= n_slen;
            r_sen       <= n_sen;
        end
    end

    `RSF_ASSERT(a_timer_vs_done, r_running != r_done, "timer running and frame done disagree")
    `RSF_ASSERT_IMP(a_send_len, r_sen, r_slen != '0 && r_slen <= DEPTH, "send enabled, bad length")
    `RSF_ASSERT(a_counts_bound, r_rc <= DEPTH && r_readable <= DEPTH && r_lc <= DEPTH,
        "buffer count beyond depth")

endmodule

`default_nettype wire

>>> hdl/rtu_silence_framer.sv
// A result is registered in the result stage and then in the output register.
// Throughput: one item per cycle while o_in_stall is low; a result stage and
// the output register let input continue while one result waits under output
// stall. The memories have registered reads that line up with the result stage.
// Reset (synchronous, active low) resets timer, flags, counts and gap registers;
// the byte memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// rtu_silence_framer
// Frames a serial byte stream by line silence, with banked receive buffers
// and a committed transmit message released one byte per ready event.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rtu_silence_framer #(
    parameter int BUFFER_DEPTH = rsf_pkg::BUFFER_DEPTH_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // configuration
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [rsf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [7:0]                    i_cfg_data,
    // input items
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire  [2:0]                    i_kind,
    input  wire  [7:0]                    i_data_byte,
    input  wire                           i_is_last,
    input  wire  [7:0]                    i_read_index,
    input  wire                           i_release_req,
    // result items
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic [1:0]                    o_out_kind,
    output logic [7:0]                    o_out_byte,
    output logic [8:0]                    o_frame_length
);
    import rsf_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic          acc;
    logic          s1_adv;
    t_res          res;
    t_res          r_s1;
    logic          r_s1_valid;
    logic          rx_we, rx_re, tx_we, tx_re;
    logic [AW:0]   rx_waddr, rx_raddr;
    logic [AW-1:0] tx_waddr, tx_raddr;
    logic [7:0]    wdata;
    logic [7:0]    rx_rdata, tx_rdata;
    logic [7:0]    s1_byte;

    assign o_cfg_ready = 1'b1;

    // result stage moves on when the output register is free or being taken
    assign s1_adv     = r_s1_valid && (!o_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign acc        = i_in_valid && !o_in_stall;

    rsf_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_acc         (acc),
        .i_kind        (i_kind),
        .i_data_byte   (i_data_byte),
        .i_is_last     (i_is_last),
        .i_read_index  (i_read_index),
        .i_release_req (i_release_req),
        .o_rx_we       (rx_we),
        .o_rx_waddr    (rx_waddr),
        .o_rx_re       (rx_re),
        .o_rx_raddr    (rx_raddr),
        .o_tx_we       (tx_we),
        .o_tx_waddr    (tx_waddr),
        .o_tx_re       (tx_re),
        .o_tx_raddr    (tx_raddr),
        .o_wdata       (wdata),
        .o_res         (res)
    );

    rsf_rx_bank #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_rx_bank (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (wdata),
        .i_re    (rx_re),
        .i_raddr (rx_raddr),
        .o_rdata (rx_rdata)
    );

    rsf_tx_store #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_tx_store (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (wdata),
        .i_re    (tx_re),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rdata)
    );

    always_comb begin
        unique case (r_s1.kind)
            OUT_TX_BYTE: s1_byte = tx_rdata;
            OUT_RD_DATA: s1_byte = r_s1.hit ? rx_rdata : 8'd0;
            default:     s1_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc && res.valid) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (s1_adv) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            o_out_kind     <= r_s1.kind;
            o_out_byte     <= s1_byte;
            o_frame_length <= r_s1.len;
        end
    end

    `RSF_ASSERT_IMP(a_s1_blocked, r_s1_valid && o_out_valid && i_out_stall, o_in_stall,
        "item accepted while result stage is blocked")

endmodule

`default_nettype wire
